FILE: rtl/spsgc_pkg.sv
// Shared constants for the segmented prime sieve gap coder.
// No dependencies; used by segmented_prime_sieve_gap_coder.
package spsgc_pkg;

  localparam int unsigned SEGMENT_ODDS     = 4096;
  localparam int unsigned SEG_AW           = $clog2(SEGMENT_ODDS);
  localparam int unsigned MAX_SMALL_PRIMES = 8192;
  localparam int unsigned TAB_AW           = $clog2(MAX_SMALL_PRIMES);
  localparam int unsigned ROOT_BOUND       = 65537;
  localparam int unsigned ROOT_DEPTH       = ROOT_BOUND + 1;
  localparam int unsigned ROOT_AW          = $clog2(ROOT_DEPTH);

  localparam logic [31:0] UPPER_LIMIT_RESET = 32'd100000000;
  localparam logic [32:0] SEGMENT_BASE_INIT = 33'd3;
  localparam logic [32:0] SEGMENT_STRIDE    = 33'(2 * SEGMENT_ODDS);
  localparam logic [12:0] SEGMENT_SPAN_MAX  = 13'(2 * SEGMENT_ODDS - 1);
  localparam logic [7:0]  GAP_ESCAPE        = 8'h00;
  localparam logic [16:0] EVEN_PRIME        = 17'd2;

endpackage

FILE: rtl/segmented_prime_sieve_gap_coder.sv
// Segmented odd-prime sieve with a gap-coded byte output stream.
// Depends on spsgc_pkg for sizes and constants.

// Each request transaction returns the next odd prime up to upper_limit as
// bytes: the first prime as four little-endian bytes, every later prime as
// its gap to the previous one (one byte, or an escape byte of zero followed
// by the gap's low and high bytes when the gap exceeds 255). When no prime is
// left, a single byte of zero with finished set is returned, repeatedly,
// until restart or a write of upper_limit (which also restarts). A limit
// write is taken only while the block is idle, and a pending write holds off
// requests in that cycle. The bitmaps and the prime table live in three
// single-port-style memories: a root composite bitmap, a small prime table
// and a segment bitmap. The first request after a restart builds the small
// primes: an integer square root, a clearing pass over the root bitmap, then
// a sieve over it and a collection pass. Each segment of 4096 odd numbers
// costs a clear, then for every small odd prime a table read, a bit-serial
// remainder unit that finds the first multiple and a walk that marks the
// multiples, and finally a scan of the entries, where each segment bitmap
// read is registered. A request that finds its prime in an already sieved
// segment only scans the segment bitmap and emits bytes; averaged over a
// segment, the cost per prime is set by the marking walk and the scan. A
// new request transaction is taken as soon as the last byte of the previous
// one sits in the output register, even while that register is stalled.
module segmented_prime_sieve_gap_coder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  code_byte_o,
  output logic        last_byte_o,
  output logic        finished_o,
  output logic [31:0] prime_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_ROOT, S_RCLR, S_SOUT, S_SOUT_W, S_SMARK, S_COLL_RD, S_COLL_CK,
    S_SEG_CHK, S_SCLR, S_PRD, S_PWAIT, S_DIV, S_START, S_MARK,
    S_SCAN_RD, S_SCAN_CK, S_EMIT, S_FIN
  } state_e;

  state_e state_q;

  // Generation state.
  logic [31:0] limit_q;
  logic [1:0]  flags_q;   // bit 0: small primes ready, bit 1: segment ready
  logic [13:0] total_q;
  logic [32:0] base_q;
  logic [12:0] scan_q;
  logic [31:0] prev_q;
  logic [31:0] emitted_q;
  logic [12:0] span_q;    // high - base of the current segment

  // Working registers.
  logic [31:0] v_q, r_q, bit_q;
  logic [16:0] sq_q, i_q, j_q, ci_q;
  logic [13:0] k_q;
  logic [16:0] p_q, rem_q;
  logic [32:0] div_q;
  logic [5:0]  cnt_q;
  logic [18:0] off_q;
  logic [31:0] word_q;
  logic [2:0]  left_q;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  code_q;
  logic        last_q, fin_q;
  logic [31:0] count_q;

  // Memories.
  logic root_mem [0:spsgc_pkg::ROOT_DEPTH-1];
  logic [16:0] tab_mem [0:spsgc_pkg::MAX_SMALL_PRIMES-1];
  logic seg_mem [0:spsgc_pkg::SEGMENT_ODDS-1];

  logic root_rd_q, seg_rd_q;
  logic [16:0] tab_rd_q;

  logic root_we, root_wdata, root_re;
  logic [spsgc_pkg::ROOT_AW-1:0] root_waddr;
  logic seg_we, seg_wdata, seg_re;
  logic [spsgc_pkg::SEG_AW-1:0] seg_waddr;
  logic tab_we, tab_re;

  logic        out_free;
  logic        out_load;
  logic        in_accept;
  logic [32:0] root_sum;
  logic [33:0] i_sq;
  logic [17:0] rem_shift;
  logic        rem_ge;
  logic [16:0] off0;
  logic [32:0] start0;
  logic [18:0] off1, off2;
  logic [31:0] limit_minus_base;
  logic [31:0] prime_now, gap_now;
  logic [17:0] sq_raw;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = out_free && ((state_q == S_EMIT) || (state_q == S_FIN));
  assign in_stall_o = (state_q != S_IDLE) || cfg_valid_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == S_IDLE);

  assign root_sum  = {1'b0, r_q} + {1'b0, bit_q};
  assign sq_raw    = {1'b0, r_q[16:0]} + 18'd1;
  assign i_sq      = i_q * i_q;
  assign rem_shift = {rem_q, div_q[32]};
  assign rem_ge    = rem_shift >= {1'b0, p_q};
  assign off0      = p_q - 17'd1 - rem_q;
  assign start0    = base_q + {16'd0, off0};
  assign off1      = (start0 == {16'd0, p_q}) ? {2'b0, off0} + {2'b0, p_q} : {2'b0, off0};
  // Base is odd, so an odd offset means an even candidate.
  assign off2      = off1[0] ? off1 + {2'b0, p_q} : off1;
  assign limit_minus_base = limit_q - base_q[31:0];
  assign prime_now = base_q[31:0] + {18'd0, scan_q, 1'b0};
  assign gap_now   = prime_now - prev_q;

  always_comb begin
    root_we    = 1'b0;
    root_wdata = 1'b0;
    root_waddr = ci_q;
    root_re    = (state_q == S_SOUT) || (state_q == S_COLL_RD);
    seg_we     = 1'b0;
    seg_wdata  = 1'b0;
    seg_waddr  = ci_q[spsgc_pkg::SEG_AW-1:0];
    seg_re     = (state_q == S_SCAN_RD);
    tab_we     = (state_q == S_COLL_CK) && !root_rd_q &&
                 (total_q < 14'(spsgc_pkg::MAX_SMALL_PRIMES));
    tab_re     = (state_q == S_PRD);
    unique case (state_q)
      S_RCLR: begin
        root_we = 1'b1;
      end
      S_SMARK: begin
        root_we    = (j_q <= sq_q);
        root_wdata = 1'b1;
        root_waddr = j_q;
      end
      S_SCLR: begin
        seg_we = 1'b1;
      end
      S_MARK: begin
        seg_we    = (off_q <= {6'd0, span_q});
        seg_wdata = 1'b1;
        seg_waddr = off_q[spsgc_pkg::SEG_AW:1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (root_we) root_mem[root_waddr] <= root_wdata;
    if (root_re) root_rd_q <= root_mem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[total_q[spsgc_pkg::TAB_AW-1:0]] <= i_q;
    if (tab_re) tab_rd_q <= tab_mem[k_q[spsgc_pkg::TAB_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (seg_we) seg_mem[seg_waddr] <= seg_wdata;
    if (seg_re) seg_rd_q <= seg_mem[scan_q[spsgc_pkg::SEG_AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= spsgc_pkg::UPPER_LIMIT_RESET;
      flags_q     <= 2'b00;
      total_q     <= '0;
      base_q      <= spsgc_pkg::SEGMENT_BASE_INIT;
      scan_q      <= '0;
      prev_q      <= '0;
      emitted_q   <= '0;
      span_q      <= '0;
      v_q         <= '0;
      r_q         <= '0;
      bit_q       <= '0;
      sq_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      ci_q        <= '0;
      k_q         <= '0;
      p_q         <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      cnt_q       <= '0;
      off_q       <= '0;
      word_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      code_q      <= '0;
      last_q      <= 1'b0;
      fin_q       <= 1'b0;
      count_q     <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            // A limit write restarts generation.
            limit_q   <= cfg_data_i;
            flags_q   <= 2'b00;
            total_q   <= '0;
            base_q    <= spsgc_pkg::SEGMENT_BASE_INIT;
            scan_q    <= '0;
            prev_q    <= '0;
            emitted_q <= '0;
          end else if (in_accept) begin
            if (restart_i || !flags_q[0]) begin
              if (restart_i) begin
                total_q   <= '0;
                base_q    <= spsgc_pkg::SEGMENT_BASE_INIT;
                scan_q    <= '0;
                prev_q    <= '0;
                emitted_q <= '0;
              end
              flags_q <= 2'b00;
              v_q     <= limit_q;
              r_q     <= '0;
              bit_q   <= 32'h4000_0000;
              state_q <= S_ROOT;
            end else begin
              state_q <= S_SEG_CHK;
            end
          end
        end
        S_ROOT: begin
          if (bit_q == '0) begin
            sq_q    <= (sq_raw > 18'(spsgc_pkg::ROOT_BOUND)) ?
                       17'(spsgc_pkg::ROOT_BOUND) : sq_raw[16:0];
            ci_q    <= '0;
            state_q <= S_RCLR;
          end else begin
            if ({1'b0, v_q} >= root_sum) begin
              v_q <= v_q - root_sum[31:0];
              r_q <= (r_q >> 1) + bit_q;
            end else begin
              r_q <= r_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        S_RCLR: begin
          ci_q <= ci_q + 17'd1;
          if (ci_q == sq_q) begin
            i_q     <= 17'd2;
            state_q <= S_SOUT;
          end
        end
        S_SOUT: begin
          if (i_sq > {17'd0, sq_q}) begin
            i_q     <= 17'd2;
            total_q <= '0;
            state_q <= S_COLL_RD;
          end else begin
            state_q <= S_SOUT_W;
          end
        end
        S_SOUT_W: begin
          if (!root_rd_q) begin
            j_q     <= i_sq[16:0];
            state_q <= S_SMARK;
          end else begin
            i_q     <= i_q + 17'd1;
            state_q <= S_SOUT;
          end
        end
        S_SMARK: begin
          if (j_q <= sq_q) begin
            j_q <= j_q + i_q;
          end else begin
            i_q     <= i_q + 17'd1;
            state_q <= S_SOUT;
          end
        end
        S_COLL_RD: begin
          if (i_q > sq_q) begin
            flags_q[0] <= 1'b1;
            state_q    <= S_SEG_CHK;
          end else begin
            state_q <= S_COLL_CK;
          end
        end
        S_COLL_CK: begin
          if (tab_we) total_q <= total_q + 14'd1;
          i_q     <= i_q + 17'd1;
          state_q <= S_COLL_RD;
        end
        S_SEG_CHK: begin
          if (flags_q[1]) begin
            state_q <= S_SCAN_RD;
          end else if (base_q > {1'b0, limit_q}) begin
            state_q <= S_FIN;
          end else begin
            span_q  <= (limit_minus_base > {19'd0, spsgc_pkg::SEGMENT_SPAN_MAX}) ?
                       spsgc_pkg::SEGMENT_SPAN_MAX : limit_minus_base[12:0];
            ci_q    <= '0;
            state_q <= S_SCLR;
          end
        end
        S_SCLR: begin
          ci_q <= ci_q + 17'd1;
          if (ci_q == 17'(spsgc_pkg::SEGMENT_ODDS - 1)) begin
            k_q     <= '0;
            state_q <= S_PRD;
          end
        end
        S_PRD: begin
          if (k_q >= total_q) begin
            flags_q[1] <= 1'b1;
            scan_q     <= '0;
            state_q    <= S_SCAN_RD;
          end else begin
            state_q <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (tab_rd_q == spsgc_pkg::EVEN_PRIME) begin
            k_q     <= k_q + 14'd1;
            state_q <= S_PRD;
          end else begin
            p_q     <= tab_rd_q;
            div_q   <= base_q + {16'd0, tab_rd_q} - 33'd1;
            rem_q   <= '0;
            cnt_q   <= 6'd33;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= rem_ge ? 17'(rem_shift - {1'b0, p_q}) : rem_shift[16:0];
          div_q <= div_q << 1;
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) state_q <= S_START;
        end
        S_START: begin
          off_q   <= off2;
          state_q <= S_MARK;
        end
        S_MARK: begin
          if (off_q <= {6'd0, span_q}) begin
            off_q <= off_q + {1'b0, p_q, 1'b0};
          end else begin
            k_q     <= k_q + 14'd1;
            state_q <= S_PRD;
          end
        end
        S_SCAN_RD: begin
          if (scan_q > {1'b0, span_q[12:1]}) begin
            base_q     <= base_q + spsgc_pkg::SEGMENT_STRIDE;
            flags_q[1] <= 1'b0;
            state_q    <= S_SEG_CHK;
          end else begin
            state_q <= S_SCAN_CK;
          end
        end
        S_SCAN_CK: begin
          scan_q <= scan_q + 13'd1;
          if (!seg_rd_q) begin
            prev_q    <= prime_now;
            emitted_q <= emitted_q + 32'd1;
            if (emitted_q == '0) begin
              word_q <= prime_now;
              left_q <= 3'd4;
            end else if (gap_now > 32'd255) begin
              word_q <= {8'd0, gap_now[15:0], spsgc_pkg::GAP_ESCAPE};
              left_q <= 3'd3;
            end else begin
              word_q <= {24'd0, gap_now[7:0]};
              left_q <= 3'd1;
            end
            state_q <= S_EMIT;
          end else begin
            state_q <= S_SCAN_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            code_q      <= word_q[7:0];
            last_q      <= (left_q == 3'd1);
            fin_q       <= 1'b0;
            count_q     <= emitted_q;
            word_q      <= word_q >> 8;
            left_q      <= left_q - 3'd1;
            if (left_q == 3'd1) state_q <= S_IDLE;
          end
        end
        S_FIN: begin
          if (out_free) begin
            code_q      <= '0;
            last_q      <= 1'b1;
            fin_q       <= 1'b1;
            count_q     <= emitted_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_byte_o   = code_q;
  assign last_byte_o   = last_q;
  assign finished_o    = fin_q;
  assign prime_count_o = count_q;

`ifndef NO_ASSERTIONS
  a_fin_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> code_byte_o == '0 && last_byte_o)
    else $error("finished result must be a single zero byte");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("request not taken into work");

  a_table_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= 14'(spsgc_pkg::MAX_SMALL_PRIMES))
    else $error("small prime table overflow");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < p_q)
    else $error("remainder out of range");
`endif

endmodule
